// File: rtl/core/rsfb_pkg.sv
package rsfb_pkg;

  // field widths of the channels
  localparam int ACTION_W   = 3;
  localparam int MODE_W     = 2;
  localparam int CHAN_W     = 8;
  localparam int IN_COORD_W = 13;
  localparam int RADIUS_W   = 12;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_HEIGHT = 2'd1;

  // internal coordinate and distance widths
  localparam int COORD_W = 15;
  localparam int SQ_W    = 27;

  localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

  typedef enum logic [ACTION_W-1:0] {
    ACT_SET_PIXEL = 3'd0,
    ACT_RECT      = 3'd1,
    ACT_CIRCLE    = 3'd2,
    ACT_FILL      = 3'd3,
    ACT_READ      = 3'd4
  } action_e;

  typedef enum logic [MODE_W-1:0] {
    BLEND_REPLACE = 2'd0,
    BLEND_ADD     = 2'd1,
    BLEND_SUB     = 2'd2
  } blend_e;

  typedef struct packed {
    logic [CHAN_W-1:0] r;
    logic [CHAN_W-1:0] g;
    logic [CHAN_W-1:0] b;
  } rgb_t;

  // one pixel handed from the scan sequencer to the pixel pipe
  typedef struct packed {
    logic               vld;
    logic [COORD_W-1:0] dx;
    logic [COORD_W-1:0] dy;
  } pix_t;

  // per-command settings, stable while a command runs
  typedef struct packed {
    logic              circle;
    logic              rd;
    logic [MODE_W-1:0] mode;
    rgb_t              paint;
    logic [SQ_W-1:0]   radsq;
  } ctl_t;

  typedef struct packed {
    logic vld;
    rgb_t rgb;
  } rd_t;

  function automatic logic [CHAN_W-1:0] blend_chan(input logic [CHAN_W-1:0] old_v,
                                                   input logic [CHAN_W-1:0] paint_v,
                                                   input logic [MODE_W-1:0] mode);
    logic [CHAN_W:0] sum;
    sum = {1'b0, old_v} + {1'b0, paint_v};
    case (mode)
      BLEND_REPLACE: return paint_v;
      BLEND_ADD:     return sum[CHAN_W] ? CHAN_MAX : sum[CHAN_W-1:0];
      BLEND_SUB:     return (old_v < paint_v) ? '0 : old_v - paint_v;
      default:       return old_v;
    endcase
  endfunction

endpackage

// File: rtl/core/rsfb_cfg_if.sv
interface rsfb_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [rsfb_pkg::CFG_IDX_W-1:0]  index;
  logic [rsfb_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/core/rsfb_cmd_if.sv
interface rsfb_cmd_if;
  logic                                valid;
  logic                                ready;
  logic [rsfb_pkg::ACTION_W-1:0]       action;
  logic [rsfb_pkg::MODE_W-1:0]         blend_mode;
  logic [rsfb_pkg::CHAN_W-1:0]         paint_red;
  logic [rsfb_pkg::CHAN_W-1:0]         paint_green;
  logic [rsfb_pkg::CHAN_W-1:0]         paint_blue;
  logic signed [rsfb_pkg::IN_COORD_W-1:0] coord_xa;
  logic signed [rsfb_pkg::IN_COORD_W-1:0] coord_ya;
  logic signed [rsfb_pkg::IN_COORD_W-1:0] coord_xb;
  logic signed [rsfb_pkg::IN_COORD_W-1:0] coord_yb;
  logic [rsfb_pkg::RADIUS_W-1:0]       circle_radius;

  modport source (output valid, action, blend_mode, paint_red, paint_green, paint_blue,
                  coord_xa, coord_ya, coord_xb, coord_yb, circle_radius, input ready);
  modport sink   (input valid, action, blend_mode, paint_red, paint_green, paint_blue,
                  coord_xa, coord_ya, coord_xb, coord_yb, circle_radius, output ready);
endinterface

// File: rtl/core/rsfb_res_if.sv
interface rsfb_res_if;
  logic                        valid;
  logic                        ready;
  logic [rsfb_pkg::CHAN_W-1:0] read_red;
  logic [rsfb_pkg::CHAN_W-1:0] read_green;
  logic [rsfb_pkg::CHAN_W-1:0] read_blue;
  logic                        read_valid;

  modport source (output valid, read_red, read_green, read_blue, read_valid, input ready);
  modport sink   (input valid, read_red, read_green, read_blue, read_valid, output ready);
endinterface

// File: rtl/core/raster_shape_fill_blend_unit.sv
// 2D drawing engine over an RGB frame store of MAX_WIDTH x MAX_HEIGHT pixels.
// cmd: one drawing command per transfer (set pixel, rectangle, circle, fill
//   frame, read pixel) with paint color, coordinates, radius and blend mode.
// res: exactly one transfer per command; read_* and read_valid carry the
//   pixel of an in-bounds read, zero otherwise.
// cfg: active width and height, written while no command is in flight;
//   always ready. Values above the maximum saturate to it.
// A command scans the clipped bounding box of its shape, one pixel per cycle,
// through a read-modify-write pipe on a single-port-read, single-port-write
// store with a registered read. A command steps through the setup, base, run,
// drain and done states, skipping run for an empty box. One command is in
// work at a time; the next can be taken in the cycle after the result is
// loaded, so the pixel scan sets the rate.
// The next command is taken as soon as the result sits in the output
// register, even while res is stalled; a second result waits until it drains.
// Reset restores width and height to their defaults and clears control state;
// store contents are undefined until a fill or draw has written them.
module raster_shape_fill_blend_unit #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rsfb_cfg_if.sink   cfg,
  rsfb_cmd_if.sink   cmd,
  rsfb_res_if.source res
);

  localparam int EffWMax = (MAX_WIDTH < 127) ? MAX_WIDTH : 127;
  localparam int EffHMax = (MAX_HEIGHT < 127) ? MAX_HEIGHT : 127;
  localparam int XW      = $clog2(EffWMax + 1);
  localparam int YW      = $clog2(EffHMax + 1);
  localparam int Depth   = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW      = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int RstW    = (64 < EffWMax) ? 64 : EffWMax;
  localparam int RstH    = (64 < EffHMax) ? 64 : EffHMax;
  localparam int CfgW    = rsfb_pkg::CFG_DATA_W;
  localparam int CW      = rsfb_pkg::COORD_W;
  localparam int SQW     = rsfb_pkg::SQ_W;
  localparam int RW      = rsfb_pkg::RADIUS_W;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StSetup = 3'd1;
  localparam logic [2:0] StBase  = 3'd2;
  localparam logic [2:0] StRun   = 3'd3;
  localparam logic [2:0] StDrain = 3'd4;
  localparam logic [2:0] StDone  = 3'd5;

  logic [2:0]    state_q;
  logic [XW-1:0] w_q;
  logic [YW-1:0] h_q;

  // command registers
  logic [rsfb_pkg::ACTION_W-1:0]           act_q;
  logic [rsfb_pkg::MODE_W-1:0]             mode_q;
  rsfb_pkg::rgb_t                          paint_q;
  logic signed [rsfb_pkg::IN_COORD_W-1:0]  xa_q, ya_q, xb_q, yb_q;
  logic [RW-1:0]                           rad_q;

  // scan sequencer
  logic [XW-1:0]  l_q, r_q, x_q;
  logic [YW-1:0]  t_q, y_q;
  logic [AW-1:0]  base_q;
  logic           empty_q;
  logic [SQW-1:0] radsq_q;

  // result
  logic           res_vld_q, res_hit_q, out_hit_q;
  rsfb_pkg::rgb_t res_rgb_q, out_rgb_q;

  logic                   cmd_xfer, load_res, busy;
  logic signed [CW-1:0]   xa_s, ya_s, xb_s, yb_s, rad_s, w_s, h_s;
  logic signed [CW-1:0]   l_s, r_s, b_s, t_s, lc, rc, bc, tc;
  logic                   empty;
  logic [2*RW-1:0]        radsq;
  logic [XW+YW-1:0]       base_init;
  rsfb_pkg::pix_t         pix;
  logic [AW-1:0]          pix_addr;
  rsfb_pkg::ctl_t         ctl;
  rsfb_pkg::rd_t          rd;

  assign cfg.ready = 1'b1;
  assign cmd.ready = (state_q == StIdle);
  assign cmd_xfer  = cmd.valid && cmd.ready;
  assign load_res  = (state_q == StDone) && (!res_vld_q || res.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q <= XW'(RstW);
      h_q <= YW'(RstH);
    end else if (cfg.valid) begin
      case (cfg.index)
        rsfb_pkg::REG_ACTIVE_WIDTH:
          w_q <= (cfg.data > CfgW'(EffWMax)) ? XW'(EffWMax) : XW'(cfg.data);
        rsfb_pkg::REG_ACTIVE_HEIGHT:
          h_q <= (cfg.data > CfgW'(EffHMax)) ? YW'(EffHMax) : YW'(cfg.data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_xfer) begin
      act_q     <= cmd.action;
      mode_q    <= cmd.blend_mode;
      paint_q.r <= cmd.paint_red;
      paint_q.g <= cmd.paint_green;
      paint_q.b <= cmd.paint_blue;
      xa_q      <= cmd.coord_xa;
      ya_q      <= cmd.coord_ya;
      xb_q      <= cmd.coord_xb;
      yb_q      <= cmd.coord_yb;
      rad_q     <= cmd.circle_radius;
    end
  end

  // bounding box of the shape, clipped to the active area
  assign xa_s  = CW'(xa_q);
  assign ya_s  = CW'(ya_q);
  assign xb_s  = CW'(xb_q);
  assign yb_s  = CW'(yb_q);
  assign rad_s = signed'(CW'(rad_q));
  assign w_s   = signed'(CW'(w_q));
  assign h_s   = signed'(CW'(h_q));

  always_comb begin
    case (act_q)
      rsfb_pkg::ACT_SET_PIXEL, rsfb_pkg::ACT_READ: begin
        l_s = xa_s;
        r_s = xa_s + CW'(1);
        b_s = ya_s;
        t_s = ya_s + CW'(1);
      end
      rsfb_pkg::ACT_RECT: begin
        l_s = xa_s;
        r_s = xb_s;
        b_s = ya_s;
        t_s = yb_s;
      end
      rsfb_pkg::ACT_CIRCLE: begin
        l_s = xa_s - rad_s;
        r_s = xa_s + rad_s;
        b_s = ya_s - rad_s;
        t_s = ya_s + rad_s;
      end
      rsfb_pkg::ACT_FILL: begin
        l_s = '0;
        r_s = w_s;
        b_s = '0;
        t_s = h_s;
      end
      default: begin
        l_s = '0;
        r_s = '0;
        b_s = '0;
        t_s = '0;
      end
    endcase
  end

  assign lc        = (l_s < 0) ? '0 : l_s;
  assign rc        = (r_s > w_s) ? w_s : r_s;
  assign bc        = (b_s < 0) ? '0 : b_s;
  assign tc        = (t_s > h_s) ? h_s : t_s;
  assign empty     = (lc >= rc) || (bc >= tc);
  assign radsq     = (2*RW)'(rad_q) * (2*RW)'(rad_q);
  assign base_init = (XW+YW)'(y_q) * (XW+YW)'(w_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      res_vld_q <= 1'b0;
    end else begin
      if (load_res) begin
        res_vld_q <= 1'b1;
      end else if (res.valid && res.ready) begin
        res_vld_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (cmd_xfer) begin
            state_q <= StSetup;
          end
        end
        StSetup: state_q <= StBase;
        StBase:  state_q <= empty_q ? StDrain : StRun;
        StRun: begin
          if ((x_q + XW'(1) == r_q) && (y_q + YW'(1) == t_q)) begin
            state_q <= StDrain;
          end
        end
        StDrain: begin
          if (!busy) begin
            state_q <= StDone;
          end
        end
        StDone: begin
          if (load_res) begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      StSetup: begin
        l_q     <= XW'(lc);
        r_q     <= XW'(rc);
        y_q     <= YW'(bc);
        t_q     <= YW'(tc);
        empty_q <= empty;
        radsq_q <= SQW'(radsq);
      end
      StBase: begin
        base_q <= AW'(base_init);
        x_q    <= l_q;
      end
      StRun: begin
        if (x_q + XW'(1) == r_q) begin
          x_q    <= l_q;
          y_q    <= y_q + YW'(1);
          base_q <= base_q + AW'(w_q);
        end else begin
          x_q <= x_q + XW'(1);
        end
      end
      default: ;
    endcase
  end

  assign pix.vld  = (state_q == StRun);
  assign pix.dx   = xa_s - signed'(CW'(x_q));
  assign pix.dy   = ya_s - signed'(CW'(y_q));
  assign pix_addr = base_q + AW'(x_q);

  assign ctl.circle = (act_q == rsfb_pkg::ACT_CIRCLE);
  assign ctl.rd     = (act_q == rsfb_pkg::ACT_READ);
  assign ctl.mode   = (act_q == rsfb_pkg::ACT_FILL) ? rsfb_pkg::BLEND_REPLACE : mode_q;
  assign ctl.paint  = paint_q;
  assign ctl.radsq  = radsq_q;

  rsfb_pixel_pipe #(
    .DEPTH (Depth),
    .AW    (AW)
  ) u_pipe (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix),
    .addr_i (pix_addr),
    .ctl_i  (ctl),
    .rd_o   (rd),
    .busy_o (busy)
  );

  // read data of the running command, then the output register
  always_ff @(posedge clk_i) begin
    if (cmd_xfer) begin
      res_rgb_q <= '0;
      res_hit_q <= 1'b0;
    end else if (rd.vld) begin
      res_rgb_q <= rd.rgb;
      res_hit_q <= 1'b1;
    end
    if (load_res) begin
      out_rgb_q <= res_rgb_q;
      out_hit_q <= res_hit_q;
    end
  end

  assign res.valid      = res_vld_q;
  assign res.read_red   = out_rgb_q.r;
  assign res.read_green = out_rgb_q.g;
  assign res.read_blue  = out_rgb_q.b;
  assign res.read_valid = out_hit_q;

  a_cmd_starts_setup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_xfer |=> state_q == StSetup)
    else $error("command transfer did not start setup");

  a_idle_pipe_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StIdle |-> !busy)
    else $error("pixel pipe busy while idle");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_vld_q) |-> $past(state_q) == StDone)
    else $error("result raised outside done state");

  a_scan_in_box: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StRun |-> (x_q < r_q) && (y_q < t_q))
    else $error("scan position outside clipped box");

endmodule

// File: rtl/core/rsfb_pixel_pipe.sv
module rsfb_pixel_pipe #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rsfb_pkg::pix_t   pix_i,
  input  logic [AW-1:0]    addr_i,
  input  rsfb_pkg::ctl_t   ctl_i,
  output rsfb_pkg::rd_t    rd_o,
  output logic             busy_o
);

  localparam int CW  = rsfb_pkg::COORD_W;
  localparam int SQW = rsfb_pkg::SQ_W;

  logic                  s1_vld_q, s2_vld_q;
  logic [AW-1:0]         s1_addr_q, s2_addr_q;
  logic [SQW-1:0]        s1_dxsq_q, s1_dysq_q;
  logic signed [2*CW-1:0] dxsq, dysq;
  logic [SQW:0]          dist_sq;
  logic                  mode_ok, hit, rd_en, wr_en;
  rsfb_pkg::rgb_t        old_q, new_px;
  rsfb_pkg::rgb_t        mem [DEPTH];

  // stage 1: squared distances from the circle center
  assign dxsq = (2*CW)'($signed(pix_i.dx)) * (2*CW)'($signed(pix_i.dx));
  assign dysq = (2*CW)'($signed(pix_i.dy)) * (2*CW)'($signed(pix_i.dy));

  // stage 2: inside test, then read the stored pixel
  assign dist_sq = {1'b0, s1_dxsq_q} + {1'b0, s1_dysq_q};
  assign mode_ok = (ctl_i.mode == rsfb_pkg::BLEND_REPLACE) ||
                   (ctl_i.mode == rsfb_pkg::BLEND_ADD) ||
                   (ctl_i.mode == rsfb_pkg::BLEND_SUB);
  assign hit     = s1_vld_q && (!ctl_i.circle || (dist_sq < {1'b0, ctl_i.radsq}));
  assign rd_en   = hit && (ctl_i.rd || mode_ok);

  // stage 3: blend and write back
  assign wr_en    = s2_vld_q && !ctl_i.rd;
  assign new_px.r = rsfb_pkg::blend_chan(old_q.r, ctl_i.paint.r, ctl_i.mode);
  assign new_px.g = rsfb_pkg::blend_chan(old_q.g, ctl_i.paint.g, ctl_i.mode);
  assign new_px.b = rsfb_pkg::blend_chan(old_q.b, ctl_i.paint.b, ctl_i.mode);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= pix_i.vld;
      s2_vld_q <= rd_en;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_addr_q <= addr_i;
    s1_dxsq_q <= dxsq[SQW-1:0];
    s1_dysq_q <= dysq[SQW-1:0];
    s2_addr_q <= s1_addr_q;
  end

  // pixels of one command never repeat an address, so read and write never collide
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[s2_addr_q] <= new_px;
    end
    if (rd_en) begin
      old_q <= mem[s1_addr_q];
    end
  end

  assign rd_o.vld = s2_vld_q && ctl_i.rd;
  assign rd_o.rgb = old_q;
  assign busy_o   = s1_vld_q || s2_vld_q;

endmodule
